/* rtl/tdpc_pkg.sv */
// Shared types and constants for the trial-division prime counter.
package tdpc_pkg;

    // Candidates at or below this value are reported not prime.
    localparam int unsigned SMALL_LIMIT = 10;
    // First odd trial divisor.
    localparam int unsigned FIRST_DIV   = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOD,
        ST_REPORT
    } t_state;

    // Status back from the bit-serial remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } t_mod_rsp;

endpackage

/* rtl/tdpc_mod_serial.sv */
// Bit-serial remainder unit: value % divisor, one dividend bit per cycle.
module tdpc_mod_serial #(
    parameter int VALUE_BITS = 31,
    parameter int DIV_BITS   = 17
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [VALUE_BITS-1:0]   i_value,
    input  logic [DIV_BITS-1:0]     i_div,
    output tdpc_pkg::t_mod_rsp      o_rsp
);
    import tdpc_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [VALUE_BITS-1:0]  r_shift;
    logic [DIV_BITS-1:0]    r_rem;
    logic [DIV_BITS-1:0]    r_div;

    logic [DIV_BITS:0]      w_trial;
    logic [DIV_BITS:0]      w_diff;
    logic                   w_ge;
    logic [DIV_BITS-1:0]    n_rem;

    // Shift the next dividend bit in, subtract if the partial remainder allows.
    always_comb begin
        w_trial = {r_rem, r_shift[VALUE_BITS-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[DIV_BITS-1:0] : w_trial[DIV_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_value;
            r_rem   <= '0;
            r_div   <= i_div;
        end else if (r_busy) begin
            r_shift <= {r_shift[VALUE_BITS-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

endmodule

/* rtl/tdpc_stats.sv */
// Running prime count (saturating) and largest prime seen.
module tdpc_stats #(
    parameter int VALUE_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_update,
    input  logic                    i_prime,
    input  logic [VALUE_BITS-1:0]   i_value,
    output logic [VALUE_BITS-1:0]   o_count_next,
    output logic [VALUE_BITS-1:0]   o_largest_next
);
    import tdpc_pkg::*;

    logic [VALUE_BITS-1:0] r_count;
    logic [VALUE_BITS-1:0] r_largest;
    logic [VALUE_BITS-1:0] n_count;
    logic [VALUE_BITS-1:0] n_largest;

    always_comb begin
        n_count   = r_count;
        n_largest = r_largest;
        if (i_prime) begin
            if (r_count != '1) begin
                n_count = r_count + VALUE_BITS'(1);
            end
            if (i_value > r_largest) begin
                n_largest = i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_largest <= '0;
        end else if (i_update) begin
            r_count   <= n_count;
            r_largest <= n_largest;
        end
    end

    assign o_count_next   = n_count;
    assign o_largest_next = n_largest;

endmodule

/* rtl/trial_division_prime_counter.sv */
// Top level of the trial-division prime counter.
//
//  channel  | dir | payload (tdata, low bit up)                        | notes
//  ---------+-----+----------------------------------------------------+-------------------
//  s_axis   | in  | candidate[VALUE_BITS], zero pad to bytes            | one request each
//  m_axis   | out | is_prime, prime_count[VB], largest_prime[VB], pad   | one result each
//
//  Flow: one request at a time. Small or even candidates go straight from the
//  accept to the report state, where the result is loaded once the output is free.
//  Otherwise each odd divisor d from 3 up with d*d <= n is tried in the bit-serial
//  remainder unit, until one divides n (composite) or d*d exceeds n (prime).
//  Reset: i_rst_n synchronous, active low; clears count, largest, FSM, valids.
//  Stalls: a finished result sits in the output register; the next request is
//  accepted and worked on meanwhile, and only its result waits for m_axis_tready.
module trial_division_prime_counter #(
    parameter int VALUE_BITS = 31
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // candidate
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((2*VALUE_BITS+8)/8)*8-1:0]   m_axis_tdata   // is_prime, prime_count,
                                                               // largest_prime
);
    import tdpc_pkg::*;

    localparam int OUT_W    = ((2*VALUE_BITS+8)/8)*8;
    // Divisor reaches just past sqrt(2^VALUE_BITS).
    localparam int DIV_BITS = VALUE_BITS/2 + 2;
    localparam int SQ_BITS  = 2*DIV_BITS;

    t_state                 r_state;
    t_state                 n_state;
    logic [VALUE_BITS-1:0]  r_value;
    logic [VALUE_BITS-1:0]  n_value;
    logic [DIV_BITS-1:0]    r_div;
    logic [DIV_BITS-1:0]    n_div;
    logic [SQ_BITS-1:0]     r_sq;        // r_div squared
    logic [SQ_BITS-1:0]     n_sq;
    logic                   r_prime;
    logic                   n_prime;

    logic                   r_out_valid;
    logic                   r_out_prime;
    logic [VALUE_BITS-1:0]  r_out_count;
    logic [VALUE_BITS-1:0]  r_out_largest;

    logic                   w_accept;
    logic                   w_load;
    logic                   w_mod_start;
    logic                   w_trivial;   // small or even: not prime, no divisions
    logic                   w_sq_over;   // divisor squared exceeds candidate
    logic [VALUE_BITS-1:0]  w_cand;
    t_mod_rsp               w_mod_rsp;
    logic [VALUE_BITS-1:0]  w_count_next;
    logic [VALUE_BITS-1:0]  w_largest_next;

    assign w_cand    = s_axis_tdata[VALUE_BITS-1:0];
    assign w_trivial = (w_cand <= VALUE_BITS'(SMALL_LIMIT)) || !w_cand[0];
    assign w_sq_over = (r_sq > {{(SQ_BITS-VALUE_BITS){1'b0}}, r_value});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_trivial ? ST_REPORT : ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = w_sq_over ? ST_REPORT : ST_MOD;
            end
            ST_MOD: begin
                if (w_mod_rsp.done) begin
                    n_state = w_mod_rsp.zero ? ST_REPORT : ST_CHECK;
                end
            end
            ST_REPORT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_mod_start   = 1'b0;
        w_load        = 1'b0;
        unique case (r_state)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_CHECK:  w_mod_start   = !w_sq_over;
            ST_MOD:    ;
            ST_REPORT: w_load        = !r_out_valid || m_axis_tready;
            default:   ;
        endcase
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Working registers: candidate, odd divisor and its square, verdict
    always_comb begin
        n_value = r_value;
        n_div   = r_div;
        n_sq    = r_sq;
        n_prime = r_prime;
        if (w_accept) begin
            n_value = w_cand;
            n_div   = DIV_BITS'(FIRST_DIV);
            n_sq    = SQ_BITS'(FIRST_DIV * FIRST_DIV);
            n_prime = 1'b0;
        end else if (r_state == ST_CHECK && w_sq_over) begin
            n_prime = 1'b1;
        end else if (r_state == ST_MOD && w_mod_rsp.done && !w_mod_rsp.zero) begin
            // (d+2)^2 = d^2 + 4d + 4
            n_div = r_div + DIV_BITS'(2);
            n_sq  = r_sq + {{(SQ_BITS-DIV_BITS-2){1'b0}}, r_div, 2'b00} + SQ_BITS'(4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_div   <= n_div;
        r_sq    <= n_sq;
        r_prime <= n_prime;
    end

    tdpc_mod_serial #(
        .VALUE_BITS (VALUE_BITS),
        .DIV_BITS   (DIV_BITS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_value (r_value),
        .i_div   (r_div),
        .o_rsp   (w_mod_rsp)
    );

    // Stats commit on the same edge the result is loaded, so it includes this item.
    tdpc_stats #(
        .VALUE_BITS (VALUE_BITS)
    ) u_stats (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_update       (w_load),
        .i_prime        (r_prime),
        .i_value        (r_value),
        .o_count_next   (w_count_next),
        .o_largest_next (w_largest_next)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_prime   <= r_prime;
            r_out_count   <= w_count_next;
            r_out_largest <= w_largest_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-2*VALUE_BITS-1){1'b0}},
                            r_out_largest, r_out_count, r_out_prime};

    // Divisor stays odd while trials run.
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK || r_state == ST_MOD) |-> r_div[0])
        else $error("trial divisor became even");

    // A prime verdict only for odd candidates above the small limit.
    a_prime_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT && r_prime) |->
            (r_value[0] && r_value > VALUE_BITS'(SMALL_LIMIT)))
        else $error("prime verdict on small or even candidate");

    // An exact division ends the search with a composite verdict.
    a_zero_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD && w_mod_rsp.done && w_mod_rsp.zero) |=>
            (r_state == ST_REPORT && !r_prime))
        else $error("zero remainder did not end the search");

    // Remainder unit finishes only while the FSM waits on it.
    a_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_rsp.done |-> (r_state == ST_MOD))
        else $error("remainder done outside wait state");

endmodule
